### hw/rtl/srde_pkg.sv
// Shared types and constants for the signed radix digit emitter.
// No dependencies; every other file uses this package, by scoped names or by import.
`default_nettype none

package srde_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned NUM_SYMS   = 16;
  localparam int unsigned SYM_IDX_W  = 4;
  localparam int unsigned TABLE_W    = NUM_SYMS * SYM_W;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned ND_W       = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned NUM_CHUNKS = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNK_CW   = $clog2(NUM_CHUNKS);

  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_DEL   = 8'h7F;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic out_minus;
    logic out_digit;
  } srde_cmd_t;

  typedef struct packed {
    logic table_ok;
    logic neg;
    logic pass_end;
    logic more;
    logic out_free;
    logic last_digit;
  } srde_sts_t;

endpackage

`default_nettype wire

### hw/rtl/signed_radix_digit_emitter.sv
// Top level of the signed radix digit emitter.
// Instantiates srde_cfg, srde_dp and srde_ctrl; uses srde_pkg.
//
// Usage: write the symbol table (index 0: symbols 0..7, index 1: symbols 8..15,
// one byte each, symbol 0 in the low byte) and the radix (index 2) over the
// cfg channel while the block is idle; cfg_ready is always high. Each beat on
// the s_axis side carries one signed 32-bit value. The m_axis side returns its
// text, most significant symbol first, one byte per beat, preceded by '-' for
// negatives; tlast marks the final digit. An invalid table gives no output.
// Sequence: accept, check the table, then one divide-by-radix pass per digit
// (one byte of the magnitude per cycle through the loop), then '-' if negative
// and the digit beats.
// s_axis_tready rises again as soon as the last beat sits in the output
// register. A stalled receiver holds the output register and pauses the digit
// sequence. Reset clears the configuration to an empty table and drops all valids.
`default_nettype none

module signed_radix_digit_emitter #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic signed [srde_pkg::VALUE_W-1:0]   s_axis_tdata,  // [31:0] value
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [srde_pkg::SYM_W-1:0]                 m_axis_tdata,  // [7:0] symbol
  output logic                                       m_axis_tlast,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [srde_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [srde_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [srde_pkg::TABLE_W-1:0]   sym_table;
  logic [$clog2(MAX_RADIX+1)-1:0] radix;
  logic                           table_ok;
  srde_pkg::srde_cmd_t            cmd;
  srde_pkg::srde_sts_t            sts;

  assign cfg_ready = 1'b1;

  srde_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sym_table (sym_table),
    .radix     (radix),
    .table_ok  (table_ok)
  );

  srde_dp #(
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (s_axis_tdata),
    .sym_table  (sym_table),
    .radix      (radix),
    .table_ok   (table_ok),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_symbol (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

  srde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

endmodule

`default_nettype wire

### hw/rtl/srde_cfg.sv
// Configuration registers and symbol table check.
// Uses srde_pkg.
`default_nettype none

module srde_cfg #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [srde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srde_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic      [srde_pkg::TABLE_W-1:0]     sym_table,
  output logic      [$clog2(MAX_RADIX+1)-1:0]   radix,
  output logic                                  table_ok
);

  localparam int unsigned RADIX_W = $clog2(MAX_RADIX + 1);

  logic [srde_pkg::CFG_DATA_W-1:0] digits_low;
  logic [srde_pkg::CFG_DATA_W-1:0] digits_high;
  logic [srde_pkg::LEN_W-1:0]      base_length;
  logic                            ok_next;

  assign sym_table = {digits_high, digits_low};

  always_comb begin
    logic [srde_pkg::SYM_W-1:0] si;
    logic                       use_i;
    ok_next = (base_length >= srde_pkg::LEN_W'(2)) &&
              (base_length <= srde_pkg::LEN_W'(MAX_RADIX));
    for (int i = 0; i < srde_pkg::NUM_SYMS; i++) begin
      si    = sym_table[i*srde_pkg::SYM_W +: srde_pkg::SYM_W];
      use_i = srde_pkg::LEN_W'(i) < base_length;
      if (use_i && ((si <= srde_pkg::SYM_SPACE) || (si >= srde_pkg::SYM_DEL) ||
                    (si == srde_pkg::SYM_PLUS) || (si == srde_pkg::SYM_MINUS)))
        ok_next = 1'b0;
      for (int j = i + 1; j < srde_pkg::NUM_SYMS; j++) begin
        if (use_i && (srde_pkg::LEN_W'(j) < base_length) &&
            (sym_table[j*srde_pkg::SYM_W +: srde_pkg::SYM_W] == si))
          ok_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_low  <= '0;
      digits_high <= '0;
      base_length <= '0;
      table_ok    <= 1'b0;
    end else begin
      table_ok <= ok_next;
      if (cfg_valid) begin
        case (cfg_index)
          srde_pkg::CFG_DIGITS_LOW:  digits_low  <= cfg_data;
          srde_pkg::CFG_DIGITS_HIGH: digits_high <= cfg_data;
          srde_pkg::CFG_BASE_LENGTH: base_length <= cfg_data[srde_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign radix = base_length[RADIX_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/srde_dp.sv
// Datapath: magnitude register, byte-wide long division, digit stack, output register.
// Uses srde_pkg; driven by srde_ctrl through srde_cmd_t.
`default_nettype none

module srde_dp #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire srde_pkg::srde_cmd_t              cmd,
  output srde_pkg::srde_sts_t                   sts,
  input  wire logic signed [srde_pkg::VALUE_W-1:0] value,
  input  wire logic [srde_pkg::TABLE_W-1:0]     sym_table,
  input  wire logic [$clog2(MAX_RADIX+1)-1:0]   radix,
  input  wire logic                             table_ok,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [srde_pkg::SYM_W-1:0]            out_symbol,
  output logic                                  out_last
);

  localparam int unsigned DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned TW      = DIGIT_W + 1;

  logic [srde_pkg::VALUE_W-1:0]  mag;
  logic                          neg;
  logic [DIGIT_W-1:0]            rem;
  logic [srde_pkg::CHUNK_CW-1:0] chunk;
  logic [srde_pkg::ND_W-1:0]     nd;
  logic [DIGIT_W-1:0]            stk [srde_pkg::MAX_DIGITS];

  logic [DIGIT_W-1:0]            rem_next;
  logic [srde_pkg::CHUNK_W-1:0]  qbyte;
  logic [srde_pkg::VALUE_W-1:0]  mag_next;
  logic [srde_pkg::VALUE_W-1:0]  raw;
  logic [srde_pkg::SYM_W-1:0]    digit_sym;
  logic [srde_pkg::SYM_IDX_W-1:0] sidx;
  logic                          out_free;

  assign raw = $unsigned(value);

  // eight restoring steps over the top byte of the magnitude
  always_comb begin
    logic [TW-1:0] t;
    logic [TW-1:0] rad;
    rad      = TW'(radix);
    rem_next = rem;
    qbyte    = '0;
    for (int b = srde_pkg::CHUNK_W - 1; b >= 0; b--) begin
      t = {rem_next, mag[srde_pkg::VALUE_W - srde_pkg::CHUNK_W + b]};
      if (t >= rad) begin
        t        = t - rad;
        qbyte[b] = 1'b1;
      end
      rem_next = t[DIGIT_W-1:0];
    end
    mag_next = {mag[srde_pkg::VALUE_W-srde_pkg::CHUNK_W-1:0], qbyte};
  end

  assign sidx      = srde_pkg::SYM_IDX_W'(stk[0]);
  assign digit_sym = sym_table[{sidx, 3'b000} +: srde_pkg::SYM_W];
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    sts.table_ok   = table_ok;
    sts.neg        = neg;
    sts.pass_end   = (chunk == srde_pkg::CHUNK_CW'(srde_pkg::NUM_CHUNKS - 1));
    sts.more       = (mag_next != '0) && (nd != srde_pkg::ND_W'(srde_pkg::MAX_DIGITS - 1));
    sts.out_free   = out_free;
    sts.last_digit = (nd == srde_pkg::ND_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk     <= '0;
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        chunk <= '0;
        nd    <= '0;
      end else if (cmd.div_step) begin
        chunk <= chunk + srde_pkg::CHUNK_CW'(1);
        if (sts.pass_end)
          nd <= nd + srde_pkg::ND_W'(1);
      end else if (cmd.out_digit) begin
        nd <= nd - srde_pkg::ND_W'(1);
      end
      if (cmd.out_minus || cmd.out_digit)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= raw[srde_pkg::VALUE_W-1];
      mag <= raw[srde_pkg::VALUE_W-1] ? (srde_pkg::VALUE_W'(0) - raw) : raw;
      rem <= '0;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      if (sts.pass_end) begin
        rem    <= '0;
        stk[0] <= rem_next;
        for (int i = 1; i < srde_pkg::MAX_DIGITS; i++)
          stk[i] <= stk[i-1];
      end else begin
        rem <= rem_next;
      end
    end else if (cmd.out_digit) begin
      for (int i = 0; i < srde_pkg::MAX_DIGITS - 1; i++)
        stk[i] <= stk[i+1];
    end
    if (cmd.out_minus) begin
      out_symbol <= srde_pkg::SYM_MINUS;
      out_last   <= 1'b0;
    end else if (cmd.out_digit) begin
      out_symbol <= digit_sym;
      out_last   <= sts.last_digit;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/srde_ctrl.sv
// Control state machine: accept, table check, division passes, sign and digit output.
// Uses srde_pkg command and status types.
`default_nettype none

module srde_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire srde_pkg::srde_sts_t  sts,
  output srde_pkg::srde_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV:   cmd.div_step  = 1'b1;
      S_SIGN:  cmd.out_minus = sts.out_free;
      S_EMIT:  cmd.out_digit = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid)
            state <= S_CHECK;
        end
        S_CHECK: state <= sts.table_ok ? S_DIV : S_IDLE;
        S_DIV: begin
          if (sts.pass_end && !sts.more)
            state <= sts.neg ? S_SIGN : S_EMIT;
        end
        S_SIGN: begin
          if (sts.out_free)
            state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free && sts.last_digit)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/srde_checker.sv
// Scoreboard for signed_radix_digit_emitter: tracks the config writes, predicts
// the symbol text of every accepted value and compares each output beat.
// Depends on srde_pkg for widths, symbol constants and register indexes.
module srde_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [srde_pkg::VALUE_W-1:0]        s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [srde_pkg::SYM_W-1:0]          m_axis_tdata,
  input  logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [srde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srde_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  open_count,
  output int                                  mismatch_count
);
  import srde_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } glyph_t;

  glyph_t             text_q[$];
  logic [TABLE_W-1:0] sym_table = '0;
  logic [LEN_W-1:0]   radix_len = '0;

  function automatic logic [SYM_W-1:0] digit_sym(input int d);
    return sym_table[d*SYM_W +: SYM_W];
  endfunction

  function automatic bit table_usable();
    logic [SYM_W-1:0] s;
    if (radix_len < 2 || radix_len > NUM_SYMS) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      s = digit_sym(i);
      if (s <= SYM_SPACE || s >= SYM_DEL || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_len; j++) begin
        if (digit_sym(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // digits are produced least significant first, then pushed in reverse
  function automatic void queue_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    int                 rev[MAX_DIGITS];
    int                 nd;
    if (!table_usable()) return;
    radix = VALUE_W'(radix_len);
    mag = raw[VALUE_W-1] ? -raw : raw;
    nd = 0;
    do begin
      rev[nd] = int'(mag % radix);
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (raw[VALUE_W-1]) text_q.push_back(glyph_t'{SYM_MINUS, 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      text_q.push_back(glyph_t'{digit_sym(rev[k]), k == 0});
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual symbol %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata !== want.symbol) begin
            $display("%0t: symbol mismatch: expected %h, actual %h",
                     $time, want.symbol, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: tlast mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIGITS_LOW: begin
            sym_table[CFG_DATA_W-1:0] = cfg_data;
          end
          CFG_DIGITS_HIGH: begin
            sym_table[TABLE_W-1:CFG_DATA_W] = cfg_data;
          end
          CFG_BASE_LENGTH: begin
            radix_len = cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) queue_text(s_axis_tdata);
    end
    open_count <= text_q.size();
  end

endmodule

### verif/signed_radix_digit_emitter_tb.sv
// Testbench top for signed_radix_digit_emitter: reset, symbol table setup,
// directed and random values with random stalls on both streams, verdict.
// Depends on srde_pkg, the block itself and srde_checker for the compare.
module signed_radix_digit_emitter_tb;
  import srde_pkg::*;

  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 480;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SYM_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    open_count;
  int                    mismatch_count;
  int                    idle_pct = 0;
  bit                    hold_req = 1'b0;
  int                    stuck_cycles = 0;

  always #10 clk = ~clk;

  signed_radix_digit_emitter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  srde_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .open_count     (open_count),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // output side: random backpressure, plus one long hold on request
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [TABLE_W-1:0] text_table(input string s);
    logic [TABLE_W-1:0] t;
    t = '0;
    for (int i = 0; i < s.len(); i++) t[i*SYM_W +: SYM_W] = s[i];
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_table(input logic [TABLE_W-1:0] tbl, input logic [CFG_DATA_W-1:0] len_word);
    write_reg(CFG_DIGITS_LOW, tbl[CFG_DATA_W-1:0]);
    write_reg(CFG_DIGITS_HIGH, tbl[TABLE_W-1:CFG_DATA_W]);
    write_reg(CFG_BASE_LENGTH, len_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // all text drained, then let a value that yields nothing finish as well
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [TABLE_W-1:0] tbl;
    logic [SYM_W-1:0]   pool[$];
    logic [SYM_W-1:0]   bad_bytes[7];
    logic [VALUE_W-1:0] corner_vals[5];
    logic [VALUE_W-1:0] v;
    int                 counted;
    int                 n;
    int                 phase;
    int                 len;
    int                 pick;
    bad_bytes   = '{8'h00, SYM_SPACE, SYM_DEL, 8'h80, 8'hFF, SYM_PLUS, SYM_MINUS};
    corner_vals = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 25;

    // empty table after reset: no text
    send_value(32'd77);
    wait_idle();

    // decimal, upper bits of the length word must be dropped
    load_table(text_table("0123456789"), 64'hFFFF_FFFF_FFFF_FFE0 | 64'd10);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(-32'sd9);
    send_value(32'd1234567890);
    wait_idle();

    // unused register index leaves the table alone
    write_reg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;
    send_value(32'd42);
    wait_idle();

    load_table(text_table("01"), 64'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd5);
    wait_idle();

    load_table(text_table("0123456789ABCDEF"), 64'd16);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hDEAD_BEEF);
    wait_idle();

    // lowest and highest legal symbols, neighbors of the sign characters
    load_table(text_table("!~*,."), 64'd5);
    send_value(32'd123456);
    send_value(-32'sd7);
    wait_idle();

    // bytes past the length are ignored even if illegal
    load_table(text_table("0123"), 64'd4);
    send_value(-32'sd255);
    wait_idle();

    // rejected tables
    for (int k = 0; k < 7; k++) begin
      tbl = text_table("0123456789");
      tbl[((k % 2) ? 9 : 0)*SYM_W +: SYM_W] = bad_bytes[k];
      load_table(tbl, 64'd10);
      send_value(32'd31);
      wait_idle();
    end
    load_table(text_table("0123456780"), 64'd10);
    send_value(32'd12);
    wait_idle();
    load_table(text_table("0"), 64'd1);
    send_value(32'd3);
    wait_idle();
    load_table(text_table("0123456789ABCDEF"), 64'd17);
    send_value(32'd3);
    wait_idle();
    load_table(text_table("0123456789ABCDEF"), 64'd31);
    send_value(-32'sd3);
    wait_idle();

    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted > RANDOM_ITEMS - 60) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      tbl = {$urandom, $urandom, $urandom, $urandom};
      if (phase > 0 && $urandom_range(0, 6) == 0) begin
        len = $urandom_range(0, 31);
        n = 3;
      end else begin
        pool.delete();
        for (int c = 8'h21; c <= 8'h7E; c++) begin
          if (c != SYM_PLUS && c != SYM_MINUS) pool.push_back(SYM_W'(c));
        end
        len = $urandom_range(2, 16);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, pool.size() - 1);
          tbl[i*SYM_W +: SYM_W] = pool[pick];
          pool.delete(pick);
        end
        n = $urandom_range(10, 40);
        counted += n;
      end
      load_table(tbl, {32'($urandom), 27'($urandom), 5'(len)});
      if (phase == 0) hold_req = 1'b1;
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: begin
            v = $urandom;
          end
          1: begin
            v = 32'($urandom_range(0, 400)) - 32'd200;
          end
          2: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
          end
          default: begin
            v = corner_vals[$urandom_range(0, 4)];
          end
        endcase
        send_value(v);
      end
      wait_idle();
      phase++;
    end

    if (mismatch_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/srde_pkg.sv
hw/rtl/srde_cfg.sv
hw/rtl/srde_dp.sv
hw/rtl/srde_ctrl.sv
hw/rtl/signed_radix_digit_emitter.sv
verif/srde_checker.sv
verif/signed_radix_digit_emitter_tb.sv
